>>> sv/aes_pkg.sv
// AES-128 package: S-box tables, GF(2^8) helpers and round functions.
// Used by the key expansion, the round stage and the top level. No dependencies.
package aes_pkg;

  localparam int NumRounds = 10;
  localparam int KeyWords = 44;
  localparam int RkEntries = 22;

  localparam logic [0:0] CMD_ENC = 1'b0;
  localparam logic [0:0] CMD_DEC = 1'b1;

  localparam logic [0:0] CFG_KEY_LOW = 1'b0;
  localparam logic [0:0] CFG_KEY_HIGH = 1'b1;

  typedef logic [127:0] state_t;

  typedef struct packed {
    logic   vld;
    logic   dec;
    state_t st;
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] byte_of(input state_t s, input int j);
    return s[8*j +: 8];
  endfunction

  function automatic state_t sub_bytes(input state_t s, input logic inv);
    state_t o;
    for (int j = 0; j < 16; j++) begin
      o[8*j +: 8] = inv ? INV_SBOX[s[8*j +: 8]] : SBOX[s[8*j +: 8]];
    end
    return o;
  endfunction

  function automatic state_t shift_rows(input state_t s, input logic inv);
    state_t o;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv) begin
          o[8*(r + 4*((c + r) % 4)) +: 8] = s[8*(r + 4*c) +: 8];
        end else begin
          o[8*(r + 4*c) +: 8] = s[8*(r + 4*((c + r) % 4)) +: 8];
        end
      end
    end
    return o;
  endfunction

  function automatic state_t mix_columns(input state_t s, input logic inv);
    state_t o;
    logic [7:0] a [4];
    logic [7:0] a2 [4];
    logic [7:0] a4 [4];
    logic [7:0] a8 [4];
    logic [7:0] m [4][4];
    logic [7:0] v;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k] = s[8*(4*c + k) +: 8];
        a2[k] = xtime(a[k]);
        a4[k] = xtime(a2[k]);
        a8[k] = xtime(a4[k]);
        // Coefficient products for 1,2,3 (encrypt) and 9,11,13,14 (decrypt).
        if (inv) begin
          m[k][0] = a8[k] ^ a4[k] ^ a2[k];
          m[k][1] = a8[k] ^ a2[k] ^ a[k];
          m[k][2] = a8[k] ^ a4[k] ^ a[k];
          m[k][3] = a8[k] ^ a[k];
        end else begin
          m[k][0] = a2[k];
          m[k][1] = a2[k] ^ a[k];
          m[k][2] = a[k];
          m[k][3] = a[k];
        end
      end
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) begin
          v = v ^ m[k][(k - r + 4) % 4];
        end
        o[8*(4*c + r) +: 8] = v;
      end
    end
    return o;
  endfunction

endpackage

>>> sv/aes_key_exp.sv
// Key expansion: one round key per cycle after each key register write.
// Holds all 11 round keys in registers. Depends on aes_pkg.
module aes_key_exp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  logic [127:0]   key,
  output logic           busy,
  output logic [127:0]   rk [11]
);

  logic [127:0] rk_r [11];
  logic [3:0]   cnt_r;
  logic [3:0]   cnt_nxt;
  logic [7:0]   rcon_r;
  logic [7:0]   rcon_nxt;
  logic [31:0]  t;
  logic [31:0]  w0;
  logic [31:0]  w1;
  logic [31:0]  w2;
  logic [31:0]  w3;
  logic [127:0] prev;

  always_comb begin
    prev = rk_r[cnt_r - 4'd1];
    t = {aes_pkg::SBOX[prev[103:96]], aes_pkg::SBOX[prev[127:120]],
         aes_pkg::SBOX[prev[119:112]], aes_pkg::SBOX[prev[111:104]] ^ rcon_r};
    w0 = prev[31:0] ^ t;
    w1 = prev[63:32] ^ w0;
    w2 = prev[95:64] ^ w1;
    w3 = prev[127:96] ^ w2;
    cnt_nxt = cnt_r;
    rcon_nxt = rcon_r;
    if (load) begin
      cnt_nxt = 4'd1;
      rcon_nxt = 8'h01;
    end else if (cnt_r != 4'd0 && cnt_r <= 4'(aes_pkg::NumRounds)) begin
      cnt_nxt = (cnt_r == 4'(aes_pkg::NumRounds)) ? 4'd0 : cnt_r + 4'd1;
      rcon_nxt = aes_pkg::xtime(rcon_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
      rcon_r <= 8'h01;
    end else begin
      cnt_r <= cnt_nxt;
      rcon_r <= rcon_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rk_r[0] <= key;
    end else if (cnt_r != 4'd0 && cnt_r <= 4'(aes_pkg::NumRounds)) begin
      rk_r[cnt_r] <= {w3, w2, w1, w0};
    end
  end

  assign busy = load || (cnt_r != 4'd0);
  assign rk = rk_r;

endmodule

>>> sv/aes_round.sv
// One pipelined cipher round, encrypt or decrypt per item.
// Depends on aes_pkg.
module aes_round (
  input  logic            clk,
  input  logic            rst_n,
  input  aes_pkg::stage_t in_s,
  input  logic [127:0]    enc_key,
  input  logic [127:0]    dec_key,
  input  logic            last,
  output aes_pkg::stage_t out_s
);

  aes_pkg::stage_t   s_r;
  aes_pkg::state_t   st_nxt;
  aes_pkg::state_t   sb;

  always_comb begin
    if (in_s.dec) begin
      sb = aes_pkg::sub_bytes(aes_pkg::shift_rows(in_s.st, 1'b1), 1'b1) ^ dec_key;
      st_nxt = last ? sb : aes_pkg::mix_columns(sb, 1'b1);
    end else begin
      sb = aes_pkg::shift_rows(aes_pkg::sub_bytes(in_s.st, 1'b0), 1'b0);
      st_nxt = (last ? sb : aes_pkg::mix_columns(sb, 1'b0)) ^ enc_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.vld <= 1'b0;
    end else begin
      s_r.vld <= in_s.vld;
    end
    s_r.dec <= in_s.dec;
    s_r.st <= st_nxt;
  end

  assign out_s = s_r;

endmodule

>>> sv/aes128_block_cipher_unit.sv
// AES-128 cipher unit: whitening stage plus ten round stages, one item per cycle unless busy.
// An accepted start passes the whitening register and the ten round registers to out_valid.
// A key write holds busy high while the round keys are re-expanded.
// Synchronous active-low reset clears the valid bits; round keys are undefined until written.
// The receiver cannot stall, so results stream out on out_valid.
// Depends on aes_pkg, aes_key_exp and aes_round.
module aes128_block_cipher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [63:0] in_block_low,
  input  logic [63:0] in_block_high,
  output logic        out_valid,
  output logic [63:0] out_result_low,
  output logic [63:0] out_result_high,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0]     key_low_r;
  logic [63:0]     key_high_r;
  logic [127:0]    key_nxt;
  logic            load_r;
  logic            kexp_busy;
  logic [127:0]    rk [11];
  aes_pkg::stage_t s0_r;
  aes_pkg::stage_t stg [11];

  always_comb begin
    key_nxt = {key_high_r, key_low_r};
    if (cfg_we && cfg_index == aes_pkg::CFG_KEY_LOW) key_nxt[63:0] = cfg_data;
    if (cfg_we && cfg_index == aes_pkg::CFG_KEY_HIGH) key_nxt[127:64] = cfg_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r <= '0;
      key_high_r <= '0;
      s0_r.vld <= 1'b0;
    end else begin
      key_low_r <= key_nxt[63:0];
      key_high_r <= key_nxt[127:64];
      s0_r.vld <= start && !busy;
    end
    s0_r.dec <= in_cmd;
    s0_r.st <= {in_block_high, in_block_low} ^ (in_cmd ? rk[10] : rk[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) load_r <= 1'b0;
    else load_r <= cfg_we;
  end

  aes_key_exp u_kexp (
    .clk  (clk),
    .rst_n(rst_n),
    .load (load_r),
    .key  ({key_high_r, key_low_r}),
    .busy (kexp_busy),
    .rk   (rk)
  );

  assign stg[0] = s0_r;

  for (genvar r = 1; r <= 10; r++) begin : g_rnd
    aes_round u_rnd (
      .clk    (clk),
      .rst_n  (rst_n),
      .in_s   (stg[r-1]),
      .enc_key(rk[r]),
      .dec_key(rk[10-r]),
      .last   (r == 10),
      .out_s  (stg[r])
    );
  end

  assign busy = kexp_busy;
  assign out_valid = stg[10].vld;
  assign out_result_low = stg[10].st[63:0];
  assign out_result_high = stg[10].st[127:64];

endmodule

>>> dv/testbench.sv
// Testbench for aes128_block_cipher_unit: AES-128 encrypt and decrypt items checked
// against an in-bench predictor with its own key schedule. Depends on aes_pkg.
module testbench;

  typedef struct {
    logic        cmd;
    logic [63:0] blk_lo;
    logic [63:0] blk_hi;
  } cipher_item_t;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
  } cipher_block_t;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = 1'b0;
  logic [63:0] in_block_low = '0;
  logic [63:0] in_block_high = '0;
  logic out_valid;
  logic [63:0] out_result_low;
  logic [63:0] out_result_high;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;

  aes128_block_cipher_unit DUT (.*);

  always #5 clk = ~clk;

  logic [7:0] fwd_box [256];
  logic [7:0] rev_box [256];
  logic [63:0] key_lo_q, key_hi_q;
  logic [7:0] sched [176];

  cipher_item_t pending_items [$];
  cipher_block_t expected_blocks [$];
  int error_count = 0;
  int enc_count = 0;
  int dec_count = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  bit hold_for_drain = 1'b0;

  function automatic logic [7:0] gf_double(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mult(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = gf_double(a);
    end
    return r;
  endfunction

  task automatic build_boxes();
    logic [7:0] p, q, x;
    p = 8'h01;
    q = 8'h01;
    // Walk the multiplicative group with generator 3 to derive the S-box.
    do begin
      p = p ^ gf_double(p);
      q = q ^ (q << 1);
      q = q ^ (q << 2);
      q = q ^ (q << 4);
      if (q[7]) q = q ^ 8'h09;
      x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]} ^ {q[3:0], q[7:4]};
      fwd_box[p] = x ^ 8'h63;
    end while (p != 8'h01);
    fwd_box[0] = 8'h63;
    for (int i = 0; i < 256; i++) rev_box[fwd_box[i]] = i[7:0];
  endtask

  task automatic expand_schedule();
    logic [7:0] t [4];
    logic [7:0] tmp, rc;
    rc = 8'h01;
    for (int j = 0; j < 8; j++) begin
      sched[j] = key_lo_q[8*j +: 8];
      sched[j + 8] = key_hi_q[8*j +: 8];
    end
    for (int i = 4; i < 44; i++) begin
      for (int k = 0; k < 4; k++) t[k] = sched[(i - 1)*4 + k];
      if (i % 4 == 0) begin
        tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
        for (int k = 0; k < 4; k++) t[k] = fwd_box[t[k]];
        t[0] ^= rc;
        rc = gf_double(rc);
      end
      for (int k = 0; k < 4; k++) sched[i*4 + k] = sched[(i - 4)*4 + k] ^ t[k];
    end
  endtask

  function automatic cipher_block_t aes_transform(cipher_item_t it);
    logic [7:0] s [16];
    logic [7:0] o [16];
    logic [7:0] mc [4];
    logic [7:0] fw [4];
    logic [7:0] iv [4];
    cipher_block_t res;
    int rnd;
    fw = '{8'd2, 8'd3, 8'd1, 8'd1};
    iv = '{8'd14, 8'd11, 8'd13, 8'd9};
    for (int j = 0; j < 8; j++) begin
      s[j] = it.blk_lo[8*j +: 8];
      s[j + 8] = it.blk_hi[8*j +: 8];
    end
    for (int step = 0; step <= 10; step++) begin
      rnd = it.cmd ? 10 - step : step;
      if (step > 0) begin
        if (it.cmd == aes_pkg::CMD_ENC) begin
          for (int j = 0; j < 16; j++) s[j] = fwd_box[s[j]];
          for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) o[r + 4*c] = s[r + 4*((c + r) % 4)];
        end else begin
          for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) o[r + 4*((c + r) % 4)] = s[r + 4*c];
          for (int j = 0; j < 16; j++) o[j] = rev_box[o[j]];
        end
        s = o;
      end
      if (it.cmd == aes_pkg::CMD_DEC) for (int j = 0; j < 16; j++) s[j] ^= sched[16*rnd + j];
      if (step > 0 && step < 10) begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) begin
            mc[r] = 8'h00;
            for (int k = 0; k < 4; k++)
              mc[r] ^= gf_mult(s[4*c + k], it.cmd ? iv[(k - r + 4) % 4] : fw[(k - r + 4) % 4]);
          end
          for (int r = 0; r < 4; r++) s[4*c + r] = mc[r];
        end
      end
      if (it.cmd == aes_pkg::CMD_ENC) for (int j = 0; j < 16; j++) s[j] ^= sched[16*rnd + j];
    end
    for (int j = 0; j < 8; j++) begin
      res.lo[8*j +: 8] = s[j];
      res.hi[8*j +: 8] = s[j + 8];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  // Driver: one item at a time from the pending queue, random gaps between items.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_blocks.push_back(aes_transform('{in_cmd, in_block_low, in_block_high}));
      if (in_cmd == aes_pkg::CMD_ENC) enc_count++; else dec_count++;
      void'(pending_items.pop_front());
      gap_left = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap_left = 0;
    end
    if (!rst_n || (start && !busy)) begin
      if (rst_n && gap_left == 0 && pending_items.size() > 0 && !hold_for_drain) begin
        start <= 1'b1;
        in_cmd <= pending_items[0].cmd;
        in_block_low <= pending_items[0].blk_lo;
        in_block_high <= pending_items[0].blk_hi;
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap_left > 0) gap_left--;
      else if (pending_items.size() > 0 && !hold_for_drain) begin
        start <= 1'b1;
        in_cmd <= pending_items[0].cmd;
        in_block_low <= pending_items[0].blk_lo;
        in_block_high <= pending_items[0].blk_hi;
      end
    end
  end

  // Monitor: compare each strobed result with the oldest prediction.
  always @(posedge clk) begin
    cipher_block_t want;
    if (rst_n && out_valid) begin
      if (expected_blocks.size() == 0) begin
        report_mismatch("result with no item outstanding", out_result_low, 64'h0);
      end else begin
        want = expected_blocks.pop_front();
        if (out_result_low !== want.lo) report_mismatch("result_low", out_result_low, want.lo);
        if (out_result_high !== want.hi) report_mismatch("result_high", out_result_high, want.hi);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d results outstanding", expected_blocks.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_key(bit idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == aes_pkg::CFG_KEY_LOW) key_lo_q = val; else key_hi_q = val;
    expand_schedule();
  endtask

  task automatic drain_all();
    wait (pending_items.size() == 0 && !start);
    while (expected_blocks.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic queue_item(logic cmd, logic [63:0] lo, logic [63:0] hi);
    pending_items.push_back('{cmd, lo, hi});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] shaped64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'h1 << $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  initial begin
    logic [63:0] keys [6];
    cipher_block_t ct;
    build_boxes();
    keys = '{64'h0, 64'hffffffffffffffff, 64'h0706050403020100,
             64'h0f0e0d0c0b0a0908, 64'h0, 64'h0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (DrainCycles) @(posedge clk);

    // Standard test key 000102..0f, then its published vector and the inverse.
    write_key(aes_pkg::CFG_KEY_LOW, keys[2]);
    write_key(aes_pkg::CFG_KEY_HIGH, keys[3]);
    queue_item(aes_pkg::CMD_ENC, 64'h7766554433221100, 64'hffeeddccbbaa9988);
    queue_item(aes_pkg::CMD_DEC, 64'h30047b6ad8e0c469, 64'h5ac5b47080b7cdd8);
    queue_item(aes_pkg::CMD_ENC, '0, '0);
    queue_item(aes_pkg::CMD_DEC, '1, '1);
    queue_item(aes_pkg::CMD_ENC, '1, '0);
    queue_item(aes_pkg::CMD_DEC, '0, '1);
    ct = aes_transform('{aes_pkg::CMD_ENC, 64'h7766554433221100, 64'hffeeddccbbaa9988});
    if (ct.lo !== 64'h30047b6ad8e0c469 || ct.hi !== 64'h5ac5b47080b7cdd8)
      report_mismatch("predictor vector", ct.lo, 64'h30047b6ad8e0c469);
    drain_all();

    // Key all zeros and all ones.
    for (int k = 0; k < 2; k++) begin
      write_key(aes_pkg::CFG_KEY_LOW, keys[k]);
      write_key(aes_pkg::CFG_KEY_HIGH, keys[k]);
      for (int i = 0; i < 4; i++) queue_item(i[0], i[1] ? '1 : '0, i[1] ? '0 : '1);
      for (int i = 0; i < 4; i++) queue_item($urandom_range(0, 1), shaped64(), shaped64());
      drain_all();
    end

    // Random phases, each with a fresh key; one phase also holds for a full drain.
    for (int ph = 0; ph < 10; ph++) begin
      if ($urandom_range(0, 1)) begin
        write_key(aes_pkg::CFG_KEY_HIGH, shaped64());
        write_key(aes_pkg::CFG_KEY_LOW, shaped64());
      end else begin
        write_key(aes_pkg::CFG_KEY_LOW, shaped64());
        write_key(aes_pkg::CFG_KEY_HIGH, shaped64());
      end
      for (int i = 0; i < 53; i++) begin
        // Half the time, decrypt a known ciphertext so the item round-trips to plaintext.
        if ($urandom_range(0, 1)) begin
          ct = aes_transform('{aes_pkg::CMD_ENC, shaped64(), shaped64()});
          queue_item(aes_pkg::CMD_DEC, ct.lo, ct.hi);
        end else begin
          queue_item($urandom_range(0, 1), shaped64(), shaped64());
        end
      end
      if (ph == 4) begin
        wait (pending_items.size() < 30);
        hold_for_drain = 1'b1;
        while (expected_blocks.size() > 0 || start) @(posedge clk);
        hold_for_drain = 1'b0;
      end
      drain_all();
    end

    $display("covered %0d encrypt and %0d decrypt items across 13 key settings",
             enc_count, dec_count);
    if (error_count == 0 && expected_blocks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, expected_blocks.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> aes128_block_cipher_unit.f
sv/aes_pkg.sv
sv/aes_key_exp.sv
sv/aes_round.sv
sv/aes128_block_cipher_unit.sv
dv/testbench.sv
